[src/assert_macros.svh]
// Assertion macros shared by the form decoder RTL.
// Depends on nothing; the bodies drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");
`else
`define ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/ufd_pkg.sv]
// Types, character codes and helpers for the url form body decoder.
// No dependencies; used by every module of the block.
package ufd_pkg;

	// Parser section
	typedef enum logic [1:0] {
		SEC_KEY   = 2'd0,
		SEC_VALUE = 2'd1,
		SEC_DROP  = 2'd2
	} sec_t;

	// Escape progress
	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_HIGH = 2'd1,
		ESC_LOW  = 2'd2
	} esc_t;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	// One input request
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_body;
	} item_t;

	// One result
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       in_value;
		logic       field_end;
		logic       form_end;
		logic       error;
	} res_t;

	// Hex digit value; non-hex bytes give (code - '0') mod 256
	function automatic logic [7:0] nibble_of(input logic [7:0] c);
		logic [7:0] v;
		if (c >= CH_UA && c <= CH_UF) begin
			v = c - CH_UA + HEX_TEN;
		end else if (c >= CH_LA && c <= CH_LF) begin
			v = c - CH_LA + HEX_TEN;
		end else begin
			v = c - CH_ZERO;
		end
		return v;
	endfunction

endpackage

[src/ufd_in_stage.sv]
// Input register stage of the form decoder: captures one request per cycle unless stalled downstream.
// Depends on ufd_pkg.
module ufd_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ufd_pkg::item_t in_item,
	input  logic          down_free,
	output logic          adv,
	output ufd_pkg::item_t item_s1
);

	logic valid_s1;
	logic load;

	// Stage empties whenever the result side can take its outcome
	assign adv      = valid_s1 && down_free;
	assign in_ready = !valid_s1 || adv;
	assign load     = in_valid && in_ready;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

[src/ufd_decode.sv]
// Decode logic and parser state of the form decoder.
// Depends on ufd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ufd_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  ufd_pkg::item_t item_s1,
	output logic           res_valid,
	output ufd_pkg::res_t  res
);

	ufd_pkg::sec_t sec_q, sec_d;
	ufd_pkg::esc_t esc_q, esc_d;
	logic [3:0]    high_q, high_d;
	logic          started_q, started_d;
	logic          hit;
	logic [7:0]    nib;
	logic [7:0]    c;
	logic          in_drop;
	logic          at_start;
	logic          err_mid;

	assign c   = item_s1.in_byte;
	assign nib = ufd_pkg::nibble_of(c);
	assign res_valid = adv && hit;

	// Shorthands for the checks below
	assign in_drop  = (sec_q == ufd_pkg::SEC_DROP);
	assign at_start = (sec_q == ufd_pkg::SEC_KEY) && (esc_q == ufd_pkg::ESC_NONE) && !started_q;
	assign err_mid  = res_valid && res.error && !res.form_end;

	// Next state and result for the request in the stage
	always_comb begin
		sec_d     = sec_q;
		esc_d     = esc_q;
		high_d    = high_q;
		started_d = started_q;
		hit       = 1'b0;
		res       = '0;
		if (item_s1.end_of_body) begin
			hit          = 1'b1;
			res.form_end = 1'b1;
			if (sec_q == ufd_pkg::SEC_DROP || esc_q != ufd_pkg::ESC_NONE ||
			    (sec_q == ufd_pkg::SEC_KEY && started_q)) begin
				res.error = 1'b1;
			end else if (sec_q == ufd_pkg::SEC_VALUE) begin
				res.in_value  = 1'b1;
				res.field_end = 1'b1;
			end
			sec_d     = ufd_pkg::SEC_KEY;
			esc_d     = ufd_pkg::ESC_NONE;
			high_d    = '0;
			started_d = 1'b0;
		end else if (sec_q != ufd_pkg::SEC_DROP) begin
			if (c == ufd_pkg::CH_AMP) begin
				// Pair separator: closes a value, anything else is malformed
				hit       = 1'b1;
				esc_d     = ufd_pkg::ESC_NONE;
				high_d    = '0;
				started_d = 1'b0;
				if (sec_q == ufd_pkg::SEC_KEY || esc_q != ufd_pkg::ESC_NONE) begin
					sec_d     = ufd_pkg::SEC_DROP;
					res.error = 1'b1;
				end else begin
					sec_d         = ufd_pkg::SEC_KEY;
					res.in_value  = 1'b1;
					res.field_end = 1'b1;
				end
			end else if (c == ufd_pkg::CH_EQ && sec_q == ufd_pkg::SEC_KEY) begin
				// Key/value split
				hit = 1'b1;
				if (esc_q != ufd_pkg::ESC_NONE) begin
					sec_d     = ufd_pkg::SEC_DROP;
					esc_d     = ufd_pkg::ESC_NONE;
					high_d    = '0;
					started_d = 1'b0;
					res.error = 1'b1;
				end else begin
					sec_d         = ufd_pkg::SEC_VALUE;
					started_d     = 1'b1;
					res.field_end = 1'b1;
				end
			end else begin
				started_d = 1'b1;
				if (esc_q == ufd_pkg::ESC_HIGH) begin
					high_d = nib[3:0];
					esc_d  = ufd_pkg::ESC_LOW;
				end else if (esc_q == ufd_pkg::ESC_LOW) begin
					// Escape complete: high*16 + low, mod 256
					hit            = 1'b1;
					esc_d          = ufd_pkg::ESC_NONE;
					high_d         = '0;
					res.out_byte   = {high_q, 4'b0000} + nib;
					res.byte_valid = 1'b1;
					res.in_value   = (sec_q == ufd_pkg::SEC_VALUE);
				end else if (c == ufd_pkg::CH_PCT) begin
					esc_d = ufd_pkg::ESC_HIGH;
				end else begin
					hit            = 1'b1;
					res.out_byte   = (c == ufd_pkg::CH_PLUS) ? ufd_pkg::CH_SPACE : c;
					res.byte_valid = 1'b1;
					res.in_value   = (sec_q == ufd_pkg::SEC_VALUE);
				end
			end
		end
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q     <= ufd_pkg::SEC_KEY;
			esc_q     <= ufd_pkg::ESC_NONE;
			high_q    <= '0;
			started_q <= 1'b0;
		end else if (adv) begin
			sec_q     <= sec_d;
			esc_q     <= esc_d;
			high_q    <= high_d;
			started_q <= started_d;
		end
	end

	// An error inside the body leaves the parser dropping bytes
	`ASSERT_NEXT(a_err_drops, clk, arst_n, err_mid, in_drop)
	// End of form returns to the start
	`ASSERT_NEXT(a_form_end_resets, clk, arst_n, res_valid && res.form_end, at_start)
	// No decoded byte while dropping
	`ASSERT_NOW(a_no_byte_in_drop, clk, arst_n, res_valid && res.byte_valid, !in_drop)

endmodule

[src/ufd_out_stage.sv]
// Result register of the form decoder, parts the output from the decode stage.
// Depends on ufd_pkg.
module ufd_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_valid,
	input  ufd_pkg::res_t res,
	output logic          free,
	output logic          out_valid,
	input  logic          out_ready,
	output ufd_pkg::res_t res_q
);

	logic valid_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

endmodule

[src/url_form_body_decoder_top.sv]
// URL-encoded form body decoder, one body byte per request, at most one result.
// A request is held in the input stage; its result reaches m_axis through the result register.
// Throughput: one request per cycle; the input stalls while the result register
// holds a result that m_axis has not taken.
// Reset (arst_n low) empties both register stages and returns the parser to the key section.
// Depends on ufd_pkg, ufd_in_stage, ufd_decode, ufd_out_stage.
module url_form_body_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // end_of_body
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] byte_valid, [9] field_end,
	                                    // [10] error, [15:11] zero
	output logic        m_axis_tuser,   // in_value
	output logic        m_axis_tlast    // form_end
);

	ufd_pkg::item_t in_item;
	ufd_pkg::item_t item_s1;
	ufd_pkg::res_t  res;
	ufd_pkg::res_t  res_q;
	logic           adv;
	logic           free;
	logic           res_valid;

	assign in_item.in_byte     = s_axis_tdata;
	assign in_item.end_of_body = s_axis_tlast;

	ufd_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.down_free (free),
		.adv       (adv),
		.item_s1   (item_s1)
	);

	ufd_decode u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ufd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.free      (free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_q     (res_q)
	);

	// Output packing
	assign m_axis_tdata = {5'b00000, res_q.error, res_q.field_end, res_q.byte_valid,
	                       res_q.out_byte};
	assign m_axis_tuser = res_q.in_value;
	assign m_axis_tlast = res_q.form_end;

endmodule
